// ===== rtl/indexed_ordered_list_macros.svh =====
// assertion macros for the indexed ordered list rtl
`ifndef INDEXED_ORDERED_LIST_MACROS_SVH
`define INDEXED_ORDERED_LIST_MACROS_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define IOL_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("iol assertion failed");

// next-cycle implication
`define IOL_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("iol assertion failed");

`endif

// ===== rtl/iol_pkg.sv =====
// package: field widths, command and status codes, result type
`timescale 1ns / 1ps
package iol_pkg;

    localparam int CMD_W  = 3;
    localparam int POS_W  = 6;
    localparam int DATA_W = 32;
    localparam int STAT_W = 2;
    localparam int LEN_W  = 6;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 3'd0,
        CMD_DELETE = 3'd1,
        CMD_READ   = 3'd2,
        CMD_APPEND = 3'd3,
        CMD_POP    = 3'd4
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic [DATA_W-1:0] value_out;
        status_t           status;
        logic [LEN_W-1:0]  length;
    } result_t;

endpackage

// ===== rtl/iol_cmd_if.sv =====
// command channel interface
`timescale 1ns / 1ps
interface iol_cmd_if;
    import iol_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [POS_W-1:0]  position;
    logic [DATA_W-1:0] value_in;

    modport source (output valid, command, position, value_in, input ready);
    modport sink (input valid, command, position, value_in, output ready);
endinterface

// ===== rtl/iol_res_if.sv =====
// result channel interface
`timescale 1ns / 1ps
interface iol_res_if;
    import iol_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] value_out;
    logic [STAT_W-1:0] status;
    logic [LEN_W-1:0]  length;

    modport source (output valid, value_out, status, length, input ready);
    modport sink (input valid, value_out, status, length, output ready);
endinterface

// ===== rtl/iol_ram.sv =====
// element store: one write port, one read port, registered read data
`timescale 1ns / 1ps
module iol_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             ren,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata,
    input  logic             wen,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem[waddr] <= wdata;
        end
        if (ren)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/iol_ctrl.sv =====
// command sequencer: decodes a request and walks the element store
`timescale 1ns / 1ps
`include "indexed_ordered_list_macros.svh"
module iol_ctrl #(
    parameter int CAPACITY   = 32,
    parameter int VALUE_BITS = 32,
    localparam int AW = $clog2(CAPACITY),
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    iol_cmd_if.sink               cmd,
    output logic                  res_valid,
    output iol_pkg::result_t      res,
    input  logic                  res_ready,
    output logic                  ram_ren,
    output logic [AW-1:0]         ram_raddr,
    input  logic [VALUE_BITS-1:0] ram_rdata,
    output logic                  ram_wen,
    output logic [AW-1:0]         ram_waddr,
    output logic [VALUE_BITS-1:0] ram_wdata
);
    import iol_pkg::*;

    localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SHIFT  = 6'b000010,
        S_PUT    = 6'b000100,
        S_READ   = 6'b001000,
        S_RCAP   = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

    state_t                state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [CW-1:0]         len_reg, len_next;
    logic [AW-1:0]         idx_reg, idx_next;
    logic [AW-1:0]         end_reg, end_next;
    logic [AW-1:0]         wr_addr_reg, wr_addr_next;
    logic [AW-1:0]         p_reg, p_next;
    logic                  rd_go_reg, rd_go_next;
    logic                  wr_go_reg, wr_go_next;
    logic                  ins_reg, ins_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    status_t               status_reg, status_next;
    logic [DATA_W-1:0]     rdv_reg, rdv_next;

    logic [CMPW-1:0] pos_x;
    logic [CMPW-1:0] cnt_x;
    logic [AW-1:0]   last_idx;
    logic            full;
    logic            empty;

    assign pos_x    = CMPW'(cmd.position);
    assign cnt_x    = CMPW'(count_reg);
    assign last_idx = AW'(count_reg - CW'(1));
    assign full     = (count_reg == CW'(CAPACITY));
    assign empty    = (count_reg == '0);

    assign cmd.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        len_next     = len_reg;
        idx_next     = idx_reg;
        end_next     = end_reg;
        wr_addr_next = wr_addr_reg;
        p_next       = p_reg;
        rd_go_next   = rd_go_reg;
        wr_go_next   = wr_go_reg;
        ins_next     = ins_reg;
        val_next     = val_reg;
        status_next  = status_reg;
        rdv_next     = rdv_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    // rejected requests leave the list and its length as they are
                    val_next    = VALUE_BITS'(cmd.value_in);
                    rdv_next    = '0;
                    len_next    = count_reg;
                    status_next = ST_RANGE;
                    state_next  = S_FINISH;
                    case (cmd.command)
                        CMD_INSERT:
                        begin
                            if (pos_x <= cnt_x || pos_x == cnt_x + CMPW'(1))
                            begin
                                if (full)
                                begin
                                    status_next = ST_FULL;
                                end
                                else
                                begin
                                    status_next = ST_DONE;
                                    len_next    = count_reg + CW'(1);
                                    if (pos_x < cnt_x)
                                    begin
                                        // open a gap: move entries up, top first
                                        p_next     = AW'(pos_x);
                                        idx_next   = last_idx;
                                        end_next   = AW'(pos_x);
                                        ins_next   = 1'b1;
                                        rd_go_next = 1'b1;
                                        wr_go_next = 1'b0;
                                        state_next = S_SHIFT;
                                    end
                                    else
                                    begin
                                        p_next     = AW'(count_reg);
                                        state_next = S_PUT;
                                    end
                                end
                            end
                        end
                        CMD_DELETE:
                        begin
                            if (pos_x < cnt_x || (pos_x == cnt_x && !empty))
                            begin
                                status_next = ST_DONE;
                                len_next    = count_reg - CW'(1);
                                // index equal to the length drops the last entry
                                if (pos_x < cnt_x && AW'(pos_x) != last_idx)
                                begin
                                    idx_next   = AW'(pos_x) + AW'(1);
                                    end_next   = last_idx;
                                    ins_next   = 1'b0;
                                    rd_go_next = 1'b1;
                                    wr_go_next = 1'b0;
                                    state_next = S_SHIFT;
                                end
                            end
                        end
                        CMD_READ:
                        begin
                            if (pos_x < cnt_x)
                            begin
                                status_next = ST_DONE;
                                idx_next    = AW'(pos_x);
                                state_next  = S_READ;
                            end
                        end
                        CMD_APPEND:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                status_next = ST_DONE;
                                len_next    = count_reg + CW'(1);
                                p_next      = AW'(count_reg);
                                state_next  = S_PUT;
                            end
                        end
                        CMD_POP:
                        begin
                            if (!empty)
                            begin
                                status_next = ST_DONE;
                                len_next    = count_reg - CW'(1);
                            end
                        end
                        default:
                        begin
                            status_next = ST_RANGE;
                        end
                    endcase
                end
            end
            S_SHIFT:
            begin
                // each entry read here is written one place over in the next cycle
                wr_go_next   = rd_go_reg;
                wr_addr_next = ins_reg ? idx_reg + AW'(1) : idx_reg - AW'(1);
                if (rd_go_reg)
                begin
                    if (idx_reg == end_reg)
                    begin
                        rd_go_next = 1'b0;
                    end
                    else
                    begin
                        idx_next = ins_reg ? idx_reg - AW'(1) : idx_reg + AW'(1);
                    end
                end
                else if (wr_go_reg)
                begin
                    state_next = ins_reg ? S_PUT : S_FINISH;
                end
            end
            S_PUT:
            begin
                state_next = S_FINISH;
            end
            S_READ:
            begin
                state_next = S_RCAP;
            end
            S_RCAP:
            begin
                rdv_next   = DATA_W'(ram_rdata);
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (res_ready)
                begin
                    count_next = len_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            rd_go_reg <= 1'b0;
            wr_go_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            rd_go_reg <= rd_go_next;
            wr_go_reg <= wr_go_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg     <= len_next;
        idx_reg     <= idx_next;
        end_reg     <= end_next;
        wr_addr_reg <= wr_addr_next;
        p_reg       <= p_next;
        ins_reg     <= ins_next;
        val_reg     <= val_next;
        status_reg  <= status_next;
        rdv_reg     <= rdv_next;
    end

    assign ram_ren   = (state_reg == S_SHIFT && rd_go_reg) || (state_reg == S_READ);
    assign ram_raddr = idx_reg;
    assign ram_wen   = (state_reg == S_SHIFT && wr_go_reg) || (state_reg == S_PUT);
    assign ram_waddr = (state_reg == S_PUT) ? p_reg : wr_addr_reg;
    assign ram_wdata = (state_reg == S_PUT) ? val_reg : ram_rdata;

    assign res_valid     = (state_reg == S_FINISH);
    assign res.value_out = rdv_reg;
    assign res.status    = status_reg;
    assign res.length    = LEN_W'(len_reg);

    `IOL_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= CW'(CAPACITY))
    `IOL_ASSERT_IMPL(a_no_rw_clash, ram_wen && ram_ren, ram_waddr != ram_raddr)
    `IOL_ASSERT_IMPL(a_idle_quiet, state_reg == S_IDLE, !rd_go_reg && !wr_go_reg)
    `IOL_ASSERT_NEXT(a_finish_exit, state_reg == S_FINISH && res_ready, state_reg == S_IDLE)

endmodule

// ===== rtl/indexed_ordered_list.sv =====
// read: read, capture and finish states; append: put and finish; plain delete, rejects: finish
// insert at p moves the entries from p up, then puts; delete at p moves the later entries down
// each moved entry is written through the single write port of the store
// next request is taken the cycle after the result enters the output register
// reset clears the length to zero; the element store is not cleared
`timescale 1ns / 1ps
module indexed_ordered_list #(
    parameter int CAPACITY   = 32,
    parameter int VALUE_BITS = 32
) (
    input logic       clk,
    input logic       rst_n,
    iol_cmd_if.sink   cmd,
    iol_res_if.source rsp
);
    import iol_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    logic                  res_valid;
    logic                  res_ready;
    result_t               res;
    logic                  ram_ren;
    logic [AW-1:0]         ram_raddr;
    logic [VALUE_BITS-1:0] ram_rdata;
    logic                  ram_wen;
    logic [AW-1:0]         ram_waddr;
    logic [VALUE_BITS-1:0] ram_wdata;

    logic    rsp_vld_reg, rsp_vld_next;
    result_t rsp_data_reg;

    iol_ctrl #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready),
        .ram_ren   (ram_ren),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .ram_wen   (ram_wen),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata)
    );

    iol_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (VALUE_BITS)
    ) u_ram (
        .clk   (clk),
        .ren   (ram_ren),
        .raddr (ram_raddr),
        .rdata (ram_rdata),
        .wen   (ram_wen),
        .waddr (ram_waddr),
        .wdata (ram_wdata)
    );

    // output register frees the sequencer while the result waits
    assign res_ready = !rsp_vld_reg || rsp.ready;

    always_comb
    begin
        rsp_vld_next = rsp_vld_reg;
        if (res_ready)
        begin
            rsp_vld_next = res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_vld_reg <= 1'b0;
        end
        else
        begin
            rsp_vld_reg <= rsp_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            rsp_data_reg <= res;
        end
    end

    assign rsp.valid     = rsp_vld_reg;
    assign rsp.value_out = rsp_data_reg.value_out;
    assign rsp.status    = rsp_data_reg.status;
    assign rsp.length    = rsp_data_reg.length;

endmodule

// ===== verif/tb_top.sv =====
// testbench for indexed_ordered_list: command stimulus, list prediction, result checks
`timescale 1ns / 1ps
module tb_top;
    import iol_pkg::*;

    localparam int CAPACITY     = 32;
    localparam int RANDOM_ITEMS = 2000;
    localparam int DRAIN_CYCLES = 2 * (CAPACITY + 8);
    localparam int IDLE_LIMIT   = 4000;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [POS_W-1:0]  position;
        logic [DATA_W-1:0] value_in;
    } list_cmd_t;

    typedef struct packed {
        logic [CAPACITY-1:0][DATA_W-1:0] vals;
        int                              len;
    } list_t;

    logic clk;
    logic rst_n;

    iol_cmd_if cmd_bus ();
    iol_res_if rsp_bus ();

    indexed_ordered_list #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (DATA_W)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .rsp   (rsp_bus)
    );

    list_cmd_t pending_cmds[$];
    result_t   expected_results[$];
    list_t     model_list;
    list_t     plan_list;
    list_cmd_t next_cmd;
    logic      cmd_fired;
    int        error_count;
    int        idle_cycles;
    int        send_gap;
    int        send_calm;
    int        stall_left;
    int        rsp_calm;

    // applies one command to a list and returns the result it gives
    function automatic result_t step_list(inout list_t st, input logic [CMD_W-1:0] op,
                                          input logic [POS_W-1:0] pos,
                                          input logic [DATA_W-1:0] val);
        result_t res;
        int      p;
        int      put_at;
        int      take_at;
        p             = int'(pos);
        res.value_out = '0;
        res.status    = ST_RANGE;
        put_at        = -1;
        take_at       = -1;
        case (op)
            CMD_INSERT:
            begin
                if (p <= st.len)
                    put_at = p;
                else if (p == st.len + 1)
                    put_at = st.len;
            end
            CMD_APPEND:
                put_at = st.len;
            CMD_DELETE:
            begin
                if (p < st.len)
                    take_at = p;
                else if (p == st.len && st.len > 0)
                    take_at = st.len - 1;
            end
            CMD_READ:
            begin
                if (p < st.len)
                begin
                    res.value_out = st.vals[p];
                    res.status    = ST_DONE;
                end
            end
            CMD_POP:
            begin
                if (st.len > 0)
                    take_at = st.len - 1;
            end
            default: ;
        endcase
        // range is checked above, so a full store only matters for a legal insert or an append
        if (put_at >= 0)
        begin
            if (st.len >= CAPACITY)
                res.status = ST_FULL;
            else
            begin
                for (int i = st.len; i > put_at; i--)
                    st.vals[i] = st.vals[i-1];
                st.vals[put_at] = val;
                st.len++;
                res.status = ST_DONE;
            end
        end
        if (take_at >= 0)
        begin
            for (int i = take_at; i < st.len - 1; i++)
                st.vals[i] = st.vals[i+1];
            st.len--;
            res.status = ST_DONE;
        end
        res.length = LEN_W'(st.len);
        return res;
    endfunction

    // mostly short gaps, a few long ones, and now and then a stretch with none
    function automatic int pick_gap(inout int calm);
        int roll;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3)
        begin
            calm = $urandom_range(20, 120);
            return 0;
        end
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return '1;
        return $urandom;
    endfunction

    task automatic queue_cmd(input logic [CMD_W-1:0] op, input logic [POS_W-1:0] pos,
                             input logic [DATA_W-1:0] val);
        list_cmd_t req;
        req.command  = op;
        req.position = pos;
        req.value_in = val;
        pending_cmds = {pending_cmds, req};
        void'(step_list(plan_list, op, pos, val));
    endtask

    task automatic report_mismatch(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        error_count++;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // request driver
    always @(negedge clk)
    begin
        if (rst_n && (cmd_fired || !cmd_bus.valid))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                cmd_bus.valid <= 1'b0;
            end
            else if (pending_cmds.size() != 0)
            begin
                next_cmd = pending_cmds.pop_front();
                cmd_bus.command  <= next_cmd.command;
                cmd_bus.position <= next_cmd.position;
                cmd_bus.value_in <= next_cmd.value_in;
                cmd_bus.valid    <= 1'b1;
                send_gap = pick_gap(send_calm);
            end
            else
                cmd_bus.valid <= 1'b0;
        end
    end

    // result back-pressure
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_bus.ready <= 1'b0;
            end
            else
            begin
                rsp_bus.ready <= 1'b1;
                stall_left = pick_gap(rsp_calm);
            end
        end
    end

    // monitor: check results, predict accepted requests
    always @(posedge clk)
    begin
        result_t want;
        result_t pred;
        cmd_fired = 1'b0;
        if (rst_n)
        begin
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch($sformatf(
                        "result with nothing expected: value %0h status %0d length %0d",
                        rsp_bus.value_out, rsp_bus.status, rsp_bus.length));
                else
                begin
                    want = expected_results.pop_front();
                    if (rsp_bus.value_out !== want.value_out)
                        report_mismatch($sformatf("value_out %0h, expected %0h",
                                                  rsp_bus.value_out, want.value_out));
                    if (rsp_bus.status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  rsp_bus.status, want.status));
                    if (rsp_bus.length !== want.length)
                        report_mismatch($sformatf("length %0d, expected %0d",
                                                  rsp_bus.length, want.length));
                end
            end
            if (cmd_bus.valid && cmd_bus.ready)
            begin
                pred = step_list(model_list, cmd_bus.command, cmd_bus.position,
                                 cmd_bus.value_in);
                expected_results = {expected_results, pred};
                cmd_fired = 1'b1;
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_bus.valid && cmd_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        int kind;
        int run;
        int len;
        int roll;
        int unused_op;
        rst_n            = 1'b0;
        cmd_bus.valid    = 1'b0;
        cmd_bus.command  = CMD_READ;
        cmd_bus.position = '0;
        cmd_bus.value_in = '0;
        rsp_bus.ready    = 1'b0;
        cmd_fired        = 1'b0;
        error_count      = 0;
        idle_cycles      = 0;
        send_gap         = 0;
        send_calm        = 0;
        stall_left       = 0;
        rsp_calm         = 0;
        model_list       = '0;
        plan_list        = '0;

        // empty list: every removal and read is rejected
        queue_cmd(CMD_POP, '0, '0);
        queue_cmd(CMD_DELETE, '0, '0);
        queue_cmd(CMD_READ, '0, '0);
        queue_cmd(CMD_INSERT, '1, 32'h1234_5678);
        // insert one past the end appends
        queue_cmd(CMD_INSERT, POS_W'(1), '1);
        queue_cmd(CMD_INSERT, '0, '0);
        queue_cmd(CMD_APPEND, '0, 32'hA5A5_5A5A);
        queue_cmd(CMD_INSERT, POS_W'(3), 32'h8000_0001);
        queue_cmd(CMD_INSERT, POS_W'(2), $urandom);
        for (int i = 0; i < 5; i++)
            queue_cmd(CMD_READ, POS_W'(i), '0);
        queue_cmd(CMD_READ, '1, '0);
        queue_cmd(CMD_READ, POS_W'(5), '0);
        // delete at the length takes the last element
        queue_cmd(CMD_DELETE, POS_W'(5), '0);
        queue_cmd(CMD_DELETE, POS_W'(6), '0);
        queue_cmd(CMD_DELETE, POS_W'(1), '0);
        for (unused_op = int'(CMD_POP) + 1; unused_op < (1 << CMD_W); unused_op++)
            queue_cmd(CMD_W'(unused_op), POS_W'(unused_op), $urandom);
        queue_cmd(CMD_POP, '0, '0);
        queue_cmd(CMD_READ, '0, '0);
        queue_cmd(CMD_READ, POS_W'(1), '0);

        // random phases: fill toward full, drain, mixed, and noise
        while (pending_cmds.size() < RANDOM_ITEMS)
        begin
            kind = $urandom_range(0, 9);
            run  = (kind < 3) ? CAPACITY + $urandom_range(1, 6) : $urandom_range(5, 60);
            for (int i = 0; i < run; i++)
            begin
                len  = plan_list.len;
                roll = $urandom_range(0, 4);
                if (kind < 3)
                begin
                    if (roll < 2)
                        queue_cmd(CMD_APPEND, POS_W'($urandom), pick_value());
                    else if (roll < 4)
                        queue_cmd(CMD_INSERT, POS_W'($urandom_range(0, len + 1)), pick_value());
                    else
                        queue_cmd(CMD_READ, POS_W'($urandom_range(0, len)), '0);
                end
                else if (kind < 6)
                begin
                    if (roll < 2)
                        queue_cmd(CMD_DELETE, POS_W'($urandom_range(0, len)), pick_value());
                    else if (roll < 3)
                        queue_cmd(CMD_POP, POS_W'($urandom), pick_value());
                    else
                        queue_cmd(CMD_READ, POS_W'($urandom_range(0, len)), pick_value());
                end
                else if (kind < 9)
                begin
                    case (roll)
                        0: queue_cmd(CMD_INSERT, POS_W'($urandom_range(0, len + 1)), pick_value());
                        1: queue_cmd(CMD_DELETE, POS_W'($urandom_range(0, len)), pick_value());
                        2: queue_cmd(CMD_READ, POS_W'($urandom_range(0, len)), pick_value());
                        3: queue_cmd(CMD_APPEND, POS_W'($urandom), pick_value());
                        default: queue_cmd(CMD_POP, POS_W'($urandom), pick_value());
                    endcase
                end
                else
                    queue_cmd(CMD_W'($urandom), POS_W'($urandom), $urandom);
            end
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_cmds.size() != 0 || cmd_bus.valid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/iol_pkg.sv
rtl/iol_cmd_if.sv
rtl/iol_res_if.sv
rtl/iol_ram.sv
rtl/iol_ctrl.sv
rtl/indexed_ordered_list.sv
verif/tb_top.sv
